>>> design/gwrt_pkg.sv
package gwrt_pkg;

  localparam int MAX_SEGMENTS_DEF = 8;
  localparam int BLOCK_BYTES_DEF  = 4096;

  localparam int SEG_LEN_W = 32;
  localparam int OFFSET_W  = 63;
  localparam int SEG_CNT_W = 4;
  localparam int BYTES_W   = 35;
  localparam int STALL_W   = 8;
  localparam int FIRST_W   = 3;
  localparam int LEFT_W    = 4;

  localparam logic [STALL_W-1:0]  STALL_RESET = 8'd4;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX  = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_REPORT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    OC_WRITTEN     = 2'd0,
    OC_INTERRUPTED = 2'd1,
    OC_INVALID     = 2'd2,
    OC_OTHER       = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_ISSUE    = 2'd1,
    ST_DONE     = 2'd2,
    ST_FAILED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_STORM   = 3'd1,
    ERR_INVALID = 3'd2,
    ERR_OTHER   = 3'd3,
    ERR_ZERO    = 3'd4,
    ERR_STALLED = 3'd5
  } err_t;

  typedef struct packed {
    status_t               status;
    err_t                  error_kind;
    logic [FIRST_W-1:0]    first_segment;
    logic [LEFT_W-1:0]     segments_left;
    logic [OFFSET_W-1:0]   write_offset;
    logic [BYTES_W-1:0]    bytes_advanced;
    logic [BYTES_W-1:0]    total_bytes;
    logic                  misaligned_warning;
  } res_t;

  localparam res_t RES_ZERO = '{
    status: ST_ACCEPTED,
    error_kind: ERR_NONE,
    first_segment: '0,
    segments_left: '0,
    write_offset: '0,
    bytes_advanced: '0,
    total_bytes: '0,
    misaligned_warning: 1'b0
  };

endpackage

>>> design/gwrt_if.sv
interface gwrt_item_if;
  import gwrt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [SEG_LEN_W-1:0] segment_length;
  logic [OFFSET_W-1:0]  start_offset;
  logic [SEG_CNT_W-1:0] segment_count;
  logic [1:0]           outcome;
  logic [BYTES_W-1:0]   bytes_written;

  modport source (
    output valid, operation, segment_length, start_offset, segment_count,
           outcome, bytes_written,
    input  ready
  );
  modport sink (
    input  valid, operation, segment_length, start_offset, segment_count,
           outcome, bytes_written,
    output ready
  );
endinterface

interface gwrt_result_if;
  import gwrt_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  err_t                error_kind;
  logic [FIRST_W-1:0]  first_segment;
  logic [LEFT_W-1:0]   segments_left;
  logic [OFFSET_W-1:0] write_offset;
  logic [BYTES_W-1:0]  bytes_advanced;
  logic [BYTES_W-1:0]  total_bytes;
  logic                misaligned_warning;

  modport source (
    output valid, status, error_kind, first_segment, segments_left, write_offset,
           bytes_advanced, total_bytes, misaligned_warning,
    input  ready
  );
  modport sink (
    input  valid, status, error_kind, first_segment, segments_left, write_offset,
           bytes_advanced, total_bytes, misaligned_warning,
    output ready
  );
endinterface

>>> design/gwrt_len_mem.sv
module gwrt_len_mem #(
  parameter int MAX_SEGMENTS = gwrt_pkg::MAX_SEGMENTS_DEF,
  parameter int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_addr,
  input  logic [gwrt_pkg::SEG_LEN_W-1:0] wr_data,
  input  logic [IDX_W-1:0]               rd_addr,
  output logic [gwrt_pkg::SEG_LEN_W-1:0] rd_data
);
  import gwrt_pkg::*;

  logic [SEG_LEN_W-1:0] mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/gwrt_rem.sv
// Block-alignment check of the reported count; the block size is a power of two,
// so the remainder is just the low count bits.
module gwrt_rem #(
  parameter int BLOCK_BYTES = gwrt_pkg::BLOCK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gwrt_pkg::BYTES_W-1:0] value,
  output logic                         done,
  output logic                         nonzero
);

  localparam int LOG_B = $clog2(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero <= 1'b0;
    end else if (start) begin
      nonzero <= (value[LOG_B-1:0] != '0);
    end
  end

  // flag is registered at accept, well before the walk can end
  assign done = 1'b1;

endmodule

>>> design/gwrt_seq.sv
module gwrt_seq #(
  parameter int MAX_SEGMENTS = gwrt_pkg::MAX_SEGMENTS_DEF,
  parameter int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gwrt_pkg::STALL_W-1:0]   cfg_data,
  gwrt_item_if.sink                      items,
  gwrt_result_if.source                  results,
  output logic                           mem_wr_en,
  output logic [IDX_W-1:0]               mem_wr_addr,
  output logic [gwrt_pkg::SEG_LEN_W-1:0] mem_wr_data,
  output logic [IDX_W-1:0]               mem_rd_addr,
  input  logic [gwrt_pkg::SEG_LEN_W-1:0] mem_rd_data,
  output logic                           rem_start,
  output logic [gwrt_pkg::BYTES_W-1:0]   rem_value,
  input  logic                           rem_done,
  input  logic                           rem_nonzero
);
  import gwrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W = (CNT_W > SEG_CNT_W) ? CNT_W : SEG_CNT_W;
  localparam int TOT_W = SEG_LEN_W + CNT_W;
  localparam int SUB_W = BYTES_W + 1;
  localparam int OFS_W = OFFSET_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_WALK = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     loaded;
  logic [CNT_W-1:0]     active;
  logic [CNT_W-1:0]     next_seg;
  logic [CNT_W-1:0]     k;
  logic [OFFSET_W-1:0]  offset;
  logic [STALL_W-1:0]   budget;
  logic [STALL_W-1:0]   stall_limit;
  logic [TOT_W-1:0]     total;
  logic                 busy;
  logic [BYTES_W-1:0]   n_rem;
  logic [BYTES_W-1:0]   n0;
  logic                 walk_end;
  res_t                 res;
  res_t                 out_res;
  logic                 out_valid;

  logic                 accept;
  logic                 emit_fire;
  logic [CNT_W-1:0]     k_inc;
  logic [SUB_W-1:0]     sub;
  logic                 step_ok;
  logic [BYTES_W-1:0]   done_bytes;
  logic [OFS_W-1:0]     off_sum;
  logic [OFFSET_W-1:0]  off_new;
  logic                 clamp;
  logic [CNT_W-1:0]     start_cnt;
  logic [CMP_W-1:0]     seg_cnt_ext;
  logic                 sum_go;

  always_comb begin
    accept      = items.valid && items.ready;
    emit_fire   = (state == S_EMIT) && (!out_valid || results.ready);
    k_inc       = k + CNT_W'(1);
    sub         = {1'b0, n_rem} - SUB_W'(mem_rd_data);
    step_ok     = (k < active) && !sub[BYTES_W];
    done_bytes  = n0 - n_rem;
    off_sum     = {1'b0, offset} + OFS_W'(done_bytes);
    off_new     = off_sum[OFFSET_W] ? OFFSET_MAX : off_sum[OFFSET_W-1:0];
    seg_cnt_ext = CMP_W'(items.segment_count);
    clamp       = seg_cnt_ext > CMP_W'(loaded);
    start_cnt   = clamp ? loaded : seg_cnt_ext[CNT_W-1:0];
    sum_go      = (items.operation == OP_START) && !busy && (start_cnt != '0);
  end

  // loads only happen in idle, so a write never meets a pending read
  assign mem_wr_en   = accept && (items.operation == OP_LOAD) && !busy &&
                       (loaded < CNT_W'(MAX_SEGMENTS));
  assign mem_wr_addr = loaded[IDX_W-1:0];
  assign mem_wr_data = items.segment_length;

  // read one entry ahead so a step can retire a segment every cycle
  always_comb begin
    unique case (state)
      S_IDLE:        mem_rd_addr = (items.operation == OP_START) ? '0 : next_seg[IDX_W-1:0];
      S_SUM, S_WALK: mem_rd_addr = k_inc[IDX_W-1:0];
      default:       mem_rd_addr = '0;
    endcase
  end

  assign rem_start = accept && (items.operation == OP_REPORT) && busy &&
                     (items.outcome == OC_WRITTEN) && (items.bytes_written != '0);
  assign rem_value = items.bytes_written;

  assign items.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      loaded      <= '0;
      active      <= '0;
      next_seg    <= '0;
      offset      <= '0;
      budget      <= '0;
      total       <= '0;
      busy        <= 1'b0;
      walk_end    <= 1'b0;
      out_valid   <= 1'b0;
      res         <= RES_ZERO;
      stall_limit <= STALL_RESET;
    end else begin
      if (cfg_we) begin
        stall_limit <= cfg_data;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= sum_go ? S_SUM : (rem_start ? S_WALK : S_EMIT);
            unique case (items.operation)
              OP_LOAD: begin
                if (mem_wr_en) begin
                  loaded <= loaded + CNT_W'(1);
                end
              end
              OP_START: begin
                if (!busy) begin
                  total  <= '0;
                  active <= start_cnt;
                  offset <= items.start_offset;
                  k      <= '0;
                  if (start_cnt == '0) begin
                    res.status <= ST_DONE;
                    loaded     <= '0;
                  end
                end
              end
              OP_REPORT: begin
                if (busy) begin
                  unique case (items.outcome)
                    OC_INTERRUPTED: begin
                      if (budget == '0) begin
                        res.status     <= ST_FAILED;
                        res.error_kind <= ERR_STORM;
                        busy           <= 1'b0;
                        loaded         <= '0;
                      end else begin
                        budget            <= budget - STALL_W'(1);
                        res.status        <= ST_ISSUE;
                        res.first_segment <= FIRST_W'(next_seg);
                        res.segments_left <= LEFT_W'(active - next_seg);
                        res.write_offset  <= offset;
                      end
                    end
                    OC_INVALID: begin
                      res.status     <= ST_FAILED;
                      res.error_kind <= ERR_INVALID;
                      busy           <= 1'b0;
                      loaded         <= '0;
                    end
                    OC_OTHER: begin
                      res.status     <= ST_FAILED;
                      res.error_kind <= ERR_OTHER;
                      busy           <= 1'b0;
                      loaded         <= '0;
                    end
                    OC_WRITTEN: begin
                      if (items.bytes_written == '0) begin
                        res.status     <= ST_FAILED;
                        res.error_kind <= ERR_ZERO;
                        busy           <= 1'b0;
                        loaded         <= '0;
                      end else begin
                        n_rem    <= items.bytes_written;
                        n0       <= items.bytes_written;
                        k        <= next_seg;
                        walk_end <= 1'b0;
                      end
                    end
                  endcase
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SUM: begin
          total <= total + TOT_W'(mem_rd_data);
          k     <= k_inc;
          if (k_inc == active) begin
            busy              <= 1'b1;
            budget            <= stall_limit;
            next_seg          <= '0;
            res.status        <= ST_ISSUE;
            res.first_segment <= '0;
            res.segments_left <= LEFT_W'(active);
            res.write_offset  <= offset;
            state             <= S_EMIT;
          end
        end

        S_WALK: begin
          if (!walk_end) begin
            if (step_ok) begin
              n_rem <= sub[BYTES_W-1:0];
              k     <= k_inc;
            end else begin
              walk_end <= 1'b1;
            end
          end
          if (walk_end && rem_done) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          res.misaligned_warning <= rem_nonzero;
          state                  <= S_EMIT;
          if (k == next_seg) begin
            if (budget == '0) begin
              res.status     <= ST_FAILED;
              res.error_kind <= ERR_STALLED;
              busy           <= 1'b0;
              loaded         <= '0;
            end else begin
              budget            <= budget - STALL_W'(1);
              res.status        <= ST_ISSUE;
              res.first_segment <= FIRST_W'(next_seg);
              res.segments_left <= LEFT_W'(active - next_seg);
              res.write_offset  <= offset;
            end
          end else begin
            budget             <= stall_limit;
            next_seg           <= k;
            offset             <= off_new;
            res.bytes_advanced <= done_bytes;
            if (k >= active) begin
              res.status      <= ST_DONE;
              res.total_bytes <= total[BYTES_W-1:0];
              busy            <= 1'b0;
              loaded          <= '0;
            end else begin
              res.status        <= ST_ISSUE;
              res.first_segment <= FIRST_W'(k);
              res.segments_left <= LEFT_W'(active - k);
              res.write_offset  <= off_new;
            end
          end
        end

        S_EMIT: begin
          // the working result is cleared as it moves out, ready for the next command
          if (emit_fire) begin
            out_res <= res;
            res     <= RES_ZERO;
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid              = out_valid;
  assign results.status             = out_res.status;
  assign results.error_kind         = out_res.error_kind;
  assign results.first_segment      = out_res.first_segment;
  assign results.segments_left      = out_res.segments_left;
  assign results.write_offset       = out_res.write_offset;
  assign results.bytes_advanced     = out_res.bytes_advanced;
  assign results.total_bytes        = out_res.total_bytes;
  assign results.misaligned_warning = out_res.misaligned_warning;

endmodule

>>> design/gather_write_resume_tracker_core.sv
// Gather write resume tracker.
// items: one transfer per command (load a segment length, start a transfer,
// report a write outcome). results: exactly one result per command, in order.
// cfg_we/cfg_data write the stall limit; write it only while the block is idle.
// One command is worked at a time; items.ready is high only in idle, and the
// next command is taken while the previous result still sits in the output
// register, so items.ready rises in the same cycle as results.valid.
// From the accepting edge, loads, ignored commands and reports that fail or
// reissue without a walk go straight to the emit state; a start with segments
// first sums the segment lengths (one memory read a cycle), and a byte-count
// report walks the segments, then passes through the finish state to emit.
// The report time is set by the segment walk (one length-table read a cycle);
// the block-alignment check masks the low count bits at accept and adds no wait.
// Reset returns the block to idle with no segments loaded and the stall limit
// at 4; the length table itself is not cleared.
// If results.ready is low, the finished result holds in the output register and
// the next result waits inside the block until it drains.
module gather_write_resume_tracker_core #(
  parameter int MAX_SEGMENTS = gwrt_pkg::MAX_SEGMENTS_DEF,
  parameter int BLOCK_BYTES  = gwrt_pkg::BLOCK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gwrt_pkg::STALL_W-1:0] cfg_data,
  gwrt_item_if.sink                    items,
  gwrt_result_if.source                results
);
  import gwrt_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [SEG_LEN_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [SEG_LEN_W-1:0] mem_rd_data;
  logic                 rem_start;
  logic [BYTES_W-1:0]   rem_value;
  logic                 rem_done;
  logic                 rem_nonzero;

  gwrt_len_mem #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gwrt_rem #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .value   (rem_value),
    .done    (rem_done),
    .nonzero (rem_nonzero)
  );

  gwrt_seq #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IDX_W        (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .items       (items),
    .results     (results),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .rem_start   (rem_start),
    .rem_value   (rem_value),
    .rem_done    (rem_done),
    .rem_nonzero (rem_nonzero)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("command accepted while another is in flight");

  a_issue_fields: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_ISSUE |->
      results.error_kind == ERR_NONE && results.segments_left != '0)
    else $error("write request with error or no segments");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_FAILED |->
      results.error_kind != ERR_NONE && results.bytes_advanced == '0)
    else $error("failure without error kind or with progress");

endmodule
